### rtl/bmh_pkg.sv
package bmh_pkg;

  localparam int DEF_HEAP_DEPTH = 128;
  localparam int DEF_KEY_WIDTH  = 32;

  // fixed port widths
  localparam int KEY_PORT_W   = 32;
  localparam int COUNT_PORT_W = 8;
  localparam int STATUS_W     = 2;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  // microprogram step addresses
  localparam pc_t S_I0   = 4'd0;
  localparam pc_t S_U0   = 4'd1;
  localparam pc_t S_U1   = 4'd2;
  localparam pc_t S_PUT  = 4'd3;
  localparam pc_t S_R0   = 4'd4;
  localparam pc_t S_R1   = 4'd5;
  localparam pc_t S_D0   = 4'd6;
  localparam pc_t S_D1   = 4'd7;
  localparam pc_t S_D2   = 4'd8;
  localparam pc_t S_D3   = 4'd9;
  localparam pc_t S_RF   = 4'd10;
  localparam pc_t S_RE   = 4'd11;
  localparam pc_t S_FIN  = 4'd12;
  localparam pc_t S_IDLE = 4'd13;

  // jump conditions
  typedef logic [3:0] cond_t;
  localparam cond_t C_NEVER     = 4'd0;
  localparam cond_t C_FULL      = 4'd1;
  localparam cond_t C_EMPTY     = 4'd2;
  localparam cond_t C_ROOT      = 4'd3;
  localparam cond_t C_NOT_GT_RD = 4'd4;
  localparam cond_t C_NO_LEFT   = 4'd5;
  localparam cond_t C_NO_RIGHT  = 4'd6;
  localparam cond_t C_NOT_GT_A  = 4'd7;
  localparam cond_t C_OUT_BUSY  = 4'd8;

  // memory read slot
  typedef logic [2:0] rd_t;
  localparam rd_t RD_NONE   = 3'd0;
  localparam rd_t RD_PARENT = 3'd1;
  localparam rd_t RD_LAST   = 3'd2;
  localparam rd_t RD_LEFT   = 3'd3;
  localparam rd_t RD_RIGHT  = 3'd4;

  // memory write data
  typedef logic [1:0] wr_t;
  localparam wr_t WR_NONE  = 2'd0;
  localparam wr_t WR_RDATA = 2'd1;
  localparam wr_t WR_KEY   = 2'd2;
  localparam wr_t WR_A     = 2'd3;

  // position register update
  typedef logic [2:0] pos_op_t;
  localparam pos_op_t P_KEEP    = 3'd0;
  localparam pos_op_t P_NEWLAST = 3'd1;
  localparam pos_op_t P_ROOT    = 3'd2;
  localparam pos_op_t P_PARENT  = 3'd3;
  localparam pos_op_t P_PICK    = 3'd4;

  typedef logic [1:0] cnt_op_t;
  localparam cnt_op_t N_KEEP = 2'd0;
  localparam cnt_op_t N_INC  = 2'd1;
  localparam cnt_op_t N_DEC  = 2'd2;

  // child candidate register update
  typedef logic [1:0] a_op_t;
  localparam a_op_t A_KEEP  = 2'd0;
  localparam a_op_t A_LEFT  = 2'd1;
  localparam a_op_t A_MAX   = 2'd2;

  // rd, wr, pos, cnt and done act only when the jump is not taken
  typedef struct packed {
    cond_t   cond;
    pc_t     jt;
    pc_t     nt;
    rd_t     rd;
    wr_t     wr;
    pos_op_t pos;
    cnt_op_t cnt;
    logic    key_ld;
    a_op_t   a_op;
    logic    stat_ld;
    status_t stat;
    logic    done;
    logic    idle;
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic act;
    logic load;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic root;
    logic not_gt_rd;
    logic no_left;
    logic no_right;
    logic not_gt_a;
    logic out_busy;
  } flags_t;

  function automatic uop_t ucode(input pc_t pc);
    uop_t u;
    u         = '0;
    u.cond    = C_NEVER;
    u.jt      = S_IDLE;
    u.nt      = pc + 4'd1;
    u.rd      = RD_NONE;
    u.wr      = WR_NONE;
    u.pos     = P_KEEP;
    u.cnt     = N_KEEP;
    u.a_op    = A_KEEP;
    u.stat    = ST_DONE;
    case (pc)
      S_I0: begin
        u.cond = C_FULL;      u.jt = S_RF;
        u.cnt  = N_INC;       u.pos = P_NEWLAST;
      end
      S_U0: begin
        u.cond = C_ROOT;      u.jt = S_PUT;
        u.rd   = RD_PARENT;
      end
      S_U1: begin
        u.cond = C_NOT_GT_RD; u.jt = S_PUT;
        u.wr   = WR_RDATA;    u.pos = P_PARENT;   u.nt = S_U0;
      end
      S_PUT: begin
        u.wr = WR_KEY;        u.nt = S_FIN;
      end
      S_R0: begin
        u.cond = C_EMPTY;     u.jt = S_RE;
        u.rd   = RD_LAST;
      end
      S_R1: begin
        u.key_ld = 1'b1;      u.cnt = N_DEC;      u.pos = P_ROOT;
      end
      S_D0: begin
        u.cond = C_NO_LEFT;   u.jt = S_PUT;
        u.rd   = RD_LEFT;
      end
      S_D1: begin
        u.cond = C_NO_RIGHT;  u.jt = S_D3;
        u.a_op = A_LEFT;      u.rd = RD_RIGHT;
      end
      S_D2: begin
        u.a_op = A_MAX;
      end
      S_D3: begin
        u.cond = C_NOT_GT_A;  u.jt = S_PUT;
        u.wr   = WR_A;        u.pos = P_PICK;     u.nt = S_D0;
      end
      S_RF: begin
        u.stat_ld = 1'b1;     u.stat = ST_FULL;   u.nt = S_FIN;
      end
      S_RE: begin
        u.stat_ld = 1'b1;     u.stat = ST_EMPTY;  u.nt = S_FIN;
      end
      S_FIN: begin
        u.cond = C_OUT_BUSY;  u.jt = S_FIN;
        u.done = 1'b1;        u.nt = S_IDLE;
      end
      S_IDLE: begin
        u.idle = 1'b1;        u.nt = S_IDLE;
      end
      default: begin
        u.nt = S_IDLE;
      end
    endcase
    return u;
  endfunction

endpackage

### rtl/bmh_in_if.sv
interface bmh_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  req_type;
  logic signed [bmh_pkg::KEY_PORT_W-1:0] key_value;

  modport source (output valid, req_type, key_value, input ready);
  modport sink   (input valid, req_type, key_value, output ready);
endinterface

### rtl/bmh_out_if.sv
interface bmh_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [bmh_pkg::KEY_PORT_W-1:0] top_value;
  logic [bmh_pkg::COUNT_PORT_W-1:0]      entry_count;
  logic [bmh_pkg::STATUS_W-1:0]          status;

  modport source (output valid, top_value, entry_count, status, input ready);
  modport sink   (input valid, top_value, entry_count, status, output ready);
endinterface

### rtl/bmh_useq.sv
module bmh_useq (
  input  logic            clk,
  input  logic            rst_n,
  bmh_in_if.sink          in_ch,
  input  bmh_pkg::flags_t flags,
  output bmh_pkg::ctl_t   ctl
);

  bmh_pkg::pc_t  pc_r, pc_nxt;
  bmh_pkg::uop_t uop;
  logic          taken;
  logic          fire;

  assign uop         = bmh_pkg::ucode(pc_r);
  assign in_ch.ready = uop.idle;
  assign fire        = in_ch.valid & uop.idle;

  always_comb begin
    case (uop.cond)
      bmh_pkg::C_NEVER:     taken = 1'b0;
      bmh_pkg::C_FULL:      taken = flags.full;
      bmh_pkg::C_EMPTY:     taken = flags.empty;
      bmh_pkg::C_ROOT:      taken = flags.root;
      bmh_pkg::C_NOT_GT_RD: taken = flags.not_gt_rd;
      bmh_pkg::C_NO_LEFT:   taken = flags.no_left;
      bmh_pkg::C_NO_RIGHT:  taken = flags.no_right;
      bmh_pkg::C_NOT_GT_A:  taken = flags.not_gt_a;
      bmh_pkg::C_OUT_BUSY:  taken = flags.out_busy;
      default:              taken = 1'b0;
    endcase
  end

  always_comb begin
    if (uop.idle) begin
      if (fire) begin
        pc_nxt = in_ch.req_type ? bmh_pkg::S_R0 : bmh_pkg::S_I0;
      end else begin
        pc_nxt = bmh_pkg::S_IDLE;
      end
    end else begin
      pc_nxt = taken ? uop.jt : uop.nt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= bmh_pkg::S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctl.uop  = uop;
  assign ctl.act  = ~taken;
  assign ctl.load = fire;

endmodule

### rtl/bmh_dpath.sv
module bmh_dpath #(
  parameter int HEAP_DEPTH = bmh_pkg::DEF_HEAP_DEPTH,
  parameter int KEY_WIDTH  = bmh_pkg::DEF_KEY_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  bmh_pkg::ctl_t                         ctl,
  input  logic signed [bmh_pkg::KEY_PORT_W-1:0] key_in,
  output bmh_pkg::flags_t                       flags,
  bmh_out_if.source                             out_ch
);

  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int AW = $clog2(HEAP_DEPTH);

  logic signed [KEY_WIDTH-1:0] mem [HEAP_DEPTH];

  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [CW-1:0]               pos_r, pos_nxt;
  logic [CW-1:0]               pick_r;
  logic signed [KEY_WIDTH-1:0] key_r, a_r, top_r, rdata_r;
  bmh_pkg::status_t            stat_r;

  logic                                  out_valid_r;
  logic signed [bmh_pkg::KEY_PORT_W-1:0] out_top_r;
  logic [bmh_pkg::COUNT_PORT_W-1:0]      out_cnt_r;
  bmh_pkg::status_t                      out_stat_r;

  logic [CW:0]                 left, right, rd_slot, rd_m1, wr_m1;
  logic [CW-1:0]               parent;
  logic                        re, we;
  logic [AW-1:0]               raddr, waddr;
  logic signed [KEY_WIDTH-1:0] wdata;
  logic signed [63:0]          key_ext;
  logic [63:0]                 top_ext;
  logic [31:0]                 cnt_ext;
  logic                        rd_gt_a;

  assign left    = {pos_r, 1'b0};
  assign right   = left + 1'b1;
  assign parent  = pos_r >> 1;
  assign key_ext = 64'(key_in);
  assign rd_gt_a = rdata_r > a_r;

  // status flags for the sequencer
  assign flags.full      = cnt_r == CW'(HEAP_DEPTH);
  assign flags.empty     = cnt_r == '0;
  assign flags.root      = pos_r == CW'(1);
  assign flags.not_gt_rd = ~(key_r > rdata_r);
  assign flags.no_left   = left > {1'b0, cnt_r};
  assign flags.no_right  = right > {1'b0, cnt_r};
  assign flags.not_gt_a  = ~(a_r > key_r);
  assign flags.out_busy  = out_valid_r & ~out_ch.ready;

  always_comb begin
    case (ctl.uop.rd)
      bmh_pkg::RD_PARENT: rd_slot = {1'b0, parent};
      bmh_pkg::RD_LAST:   rd_slot = {1'b0, cnt_r};
      bmh_pkg::RD_LEFT:   rd_slot = left;
      bmh_pkg::RD_RIGHT:  rd_slot = right;
      default:            rd_slot = {1'b0, cnt_r};
    endcase
  end

  // slots are one-based
  assign rd_m1 = rd_slot - 1'b1;
  assign wr_m1 = {1'b0, pos_r} - 1'b1;
  assign raddr = rd_m1[AW-1:0];
  assign waddr = wr_m1[AW-1:0];
  assign re    = ctl.act & (ctl.uop.rd != bmh_pkg::RD_NONE);
  assign we    = ctl.act & (ctl.uop.wr != bmh_pkg::WR_NONE);

  always_comb begin
    case (ctl.uop.wr)
      bmh_pkg::WR_RDATA: wdata = rdata_r;
      bmh_pkg::WR_KEY:   wdata = key_r;
      bmh_pkg::WR_A:     wdata = a_r;
      default:           wdata = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.act) begin
      case (ctl.uop.cnt)
        bmh_pkg::N_INC: cnt_nxt = cnt_r + 1'b1;
        bmh_pkg::N_DEC: cnt_nxt = cnt_r - 1'b1;
        default:        cnt_nxt = cnt_r;
      endcase
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (ctl.act) begin
      case (ctl.uop.pos)
        bmh_pkg::P_NEWLAST: pos_nxt = cnt_r + 1'b1;
        bmh_pkg::P_ROOT:    pos_nxt = CW'(1);
        bmh_pkg::P_PARENT:  pos_nxt = parent;
        bmh_pkg::P_PICK:    pos_nxt = pick_r;
        default:            pos_nxt = pos_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (ctl.load) begin
      key_r  <= key_ext[KEY_WIDTH-1:0];
      stat_r <= bmh_pkg::ST_DONE;
    end else if (ctl.uop.key_ld) begin
      key_r <= rdata_r;
    end
    if (ctl.uop.stat_ld) begin
      stat_r <= ctl.uop.stat;
    end
    case (ctl.uop.a_op)
      bmh_pkg::A_LEFT: begin
        a_r    <= rdata_r;
        pick_r <= left[CW-1:0];
      end
      bmh_pkg::A_MAX: begin
        if (rd_gt_a) begin
          a_r    <= rdata_r;
          pick_r <= right[CW-1:0];
        end
      end
      default: begin
      end
    endcase
    // shadow of slot one for the result
    if (we && flags.root) begin
      top_r <= wdata;
    end
  end

  assign top_ext = (cnt_r != '0) ? 64'($unsigned(top_r)) : 64'd0;
  assign cnt_ext = 32'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.uop.done && ctl.act) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.uop.done && ctl.act) begin
      out_top_r  <= top_ext[bmh_pkg::KEY_PORT_W-1:0];
      out_cnt_r  <= cnt_ext[bmh_pkg::COUNT_PORT_W-1:0];
      out_stat_r <= stat_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.top_value   = out_top_r;
  assign out_ch.entry_count = out_cnt_r;
  assign out_ch.status      = out_stat_r;

endmodule

### rtl/binary_max_heap_core.sv
// binary max-heap priority queue: each input beat either inserts a signed key
// (req_type 0) or removes the root (req_type 1), and every request returns one
// result beat with the maximum after the request (zero when empty), the entry
// count and a status (done, insert rejected full, removal rejected empty).
// keys live in a single-port-style memory of HEAP_DEPTH entries that is never
// cleared; only slots 1 to the count are read. a small microprogram steps a
// hole through the tree. an insert moves the hole up from the new last slot
// until it reaches the root or a compare stops the key, then writes the key and
// reports; a removal fetches the last key, moves the hole down level by level,
// makes a last check of the children (no child, left child only, two children),
// then writes the key and reports. the key moves at most log2(HEAP_DEPTH) levels.
// a rejected request goes straight to reporting. each level costs one registered
// memory read per key compared and one write, which sets the rate.
// one request is in flight at a time; a new input beat is taken in the cycle
// after the result is loaded, while that result still sits in the output
// register. the reporting step holds as long as an older result waits there.
module binary_max_heap_core #(
  parameter int HEAP_DEPTH = bmh_pkg::DEF_HEAP_DEPTH,
  parameter int KEY_WIDTH  = bmh_pkg::DEF_KEY_WIDTH
) (
  input logic       clk,
  input logic       rst_n,
  bmh_in_if.sink    in_ch,
  bmh_out_if.source out_ch
);

  // control word of the current step, plus jump outcome and input load
  bmh_pkg::ctl_t   ctl;
  // datapath conditions the microprogram branches on
  bmh_pkg::flags_t flags;

  // step counter and microcode rom
  bmh_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .flags (flags),
    .ctl   (ctl)
  );

  // key memory, count, hole position and result register
  bmh_dpath #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .key_in (in_ch.key_value),
    .flags  (flags),
    .out_ch (out_ch)
  );

endmodule
